// ===== design/rpb_pkg.sv =====
// rpb_pkg: word types, blend mode codes and shared arithmetic helpers
// for the RGBA pixel blender. Depends on nothing; imported by rgba_pixel_blend.
package rpb_pkg;

	localparam int CH_W    = 8;
	localparam int MODE_W  = 2;
	localparam int PROD_W  = 2 * CH_W;           // 8x8 product
	localparam int DEN_W   = 2 * CH_W;           // over-mode divisor, at most 65025
	localparam int NUM_W   = 3 * CH_W;           // over-mode numerator, at most 255*65025
	localparam int Q_W     = CH_W;               // quotient bits, one divider stage each
	localparam int N_COLOR = 3;                  // red, green, blue

	localparam logic [CH_W-1:0] CH_MAX = '1;

	localparam logic [MODE_W-1:0] MODE_COPY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_OVER = 2'd2;

	typedef struct packed {
		logic [CH_W-1:0] dest_red;
		logic [CH_W-1:0] dest_green;
		logic [CH_W-1:0] dest_blue;
		logic [CH_W-1:0] dest_alpha;
		logic [CH_W-1:0] src_red;
		logic [CH_W-1:0] src_green;
		logic [CH_W-1:0] src_blue;
		logic [CH_W-1:0] src_alpha;
	} pix_word_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_alpha;
	} blend_word_t;

	// Word carried through the divider stages.
	typedef struct packed {
		blend_word_t                          res;   // final word unless over colours apply
		logic                                 over;  // over mode with nonzero divisor
		logic [DEN_W-1:0]                     den;
		logic [N_COLOR-1:0][NUM_W-1:0]        rem;
		logic [N_COLOR-1:0][Q_W-1:0]          quo;
	} div_word_t;

	// floor(x/255) for x up to 65025: reciprocal trick, no divider.
	function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] t;
		t = {1'b0, x} + (PROD_W+1)'(1) + (PROD_W+1)'(x >> CH_W);
		return t[PROD_W-1:CH_W];
	endfunction

	// Saturating 8-bit add.
	function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		logic [CH_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CH_W] ? CH_MAX : s[CH_W-1:0];
	endfunction

endpackage

// ===== design/rgba_pixel_blend.sv =====
// rgba_pixel_blend: pipelined RGBA8 blender (copy, alpha-weighted add, straight alpha over).
// Depends on rpb_pkg for word types, mode codes and the div255/sat_add helpers.
//
//  channel | valid       | stall       | word                 | direction
//  --------+-------------+-------------+----------------------+----------
//  pixel   | pix_valid   | pix_stall   | pix   (pix_word_t)   | in
//  blend   | blend_valid | blend_stall | blend (blend_word_t) | out
//  mode    | mode_we     | -           | mode_wdata           | in
//
// One word in and one word out per clock when unstalled; the stages are:
// s1 products, s2 numerator/divisor sums, then an 8-stage restoring divider,
// one quotient bit per stage for the three colour lanes in parallel.
// The whole pipe, bubbles included, holds while the last stage has a word and
// blend_stall is high; otherwise every stage advances, so no word is lost or repeated.
// arst_n clears the valid bits and the mode register (copy); payload is not reset.
module rgba_pixel_blend (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        mode_we,
	input  logic [rpb_pkg::MODE_W-1:0]  mode_wdata,
	input  logic                        pix_valid,
	output logic                        pix_stall,
	input  rpb_pkg::pix_word_t          pix,
	output logic                        blend_valid,
	input  logic                        blend_stall,
	output rpb_pkg::blend_word_t        blend
);
	import rpb_pkg::*;

	// ---------------- mode register ----------------
	logic [MODE_W-1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_COPY;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	// ---------------- pipeline advance ----------------
	// Single enable: the pipe moves unless a finished word is held at the output.
	logic en;
	assign en        = !(blend_valid && blend_stall);
	assign pix_stall = !en;

	// ---------------- stage 1: products ----------------
	logic [N_COLOR-1:0][CH_W-1:0] cs_in, cd_in;
	assign cs_in = {pix.src_blue, pix.src_green, pix.src_red};
	assign cd_in = {pix.dest_blue, pix.dest_green, pix.dest_red};

	logic                            v_s1;
	pix_word_t                       pix_s1;
	logic [MODE_W-1:0]               mode_s1;
	logic [N_COLOR-1:0][PROD_W-1:0]  csas_s1;   // cs*as
	logic [N_COLOR-1:0][PROD_W-1:0]  cdad_s1;   // cd*ad
	logic [PROD_W-1:0]               adinv_s1;  // ad*(255-as)
	logic [CH_W-1:0]                 inv_as_s1; // 255-as

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1    <= pix;
			mode_s1   <= mode_q;
			inv_as_s1 <= CH_MAX - pix.src_alpha;
			adinv_s1  <= PROD_W'(pix.dest_alpha) * PROD_W'(CH_MAX - pix.src_alpha);
			for (int c = 0; c < N_COLOR; c++) begin
				csas_s1[c] <= PROD_W'(cs_in[c]) * PROD_W'(pix.src_alpha);
				cdad_s1[c] <= PROD_W'(cd_in[c]) * PROD_W'(pix.dest_alpha);
			end
		end
	end

	// ---------------- stage 2: sums, non-over results ----------------
	logic [DEN_W-1:0]               den_c;
	logic [N_COLOR-1:0][NUM_W-1:0]  num_c;
	logic [N_COLOR-1:0][CH_W-1:0]   add_c;
	logic [N_COLOR-1:0][CH_W-1:0]   cd_s1;
	blend_word_t                    res_c;
	div_word_t                      dw_c;

	assign cd_s1 = {pix_s1.dest_blue, pix_s1.dest_green, pix_s1.dest_red};

	always_comb begin
		// as*255 + ad*(255-as)
		den_c = ({pix_s1.src_alpha, {CH_W{1'b0}}} - DEN_W'(pix_s1.src_alpha)) + adinv_s1;
		for (int c = 0; c < N_COLOR; c++) begin
			num_c[c] = ({csas_s1[c], {CH_W{1'b0}}} - NUM_W'(csas_s1[c]))
				+ NUM_W'(cdad_s1[c]) * NUM_W'(inv_as_s1);
			add_c[c] = sat_add(cd_s1[c], div255(csas_s1[c]));
		end

		case (mode_s1)
			MODE_ADD: begin
				res_c.out_red   = add_c[0];
				res_c.out_green = add_c[1];
				res_c.out_blue  = add_c[2];
				res_c.out_alpha = pix_s1.dest_alpha;
			end
			MODE_OVER: begin
				// colours come from the divider; zero when both alphas are zero
				res_c.out_red   = '0;
				res_c.out_green = '0;
				res_c.out_blue  = '0;
				res_c.out_alpha = div255(den_c);
			end
			default: begin
				res_c.out_red   = pix_s1.src_red;
				res_c.out_green = pix_s1.src_green;
				res_c.out_blue  = pix_s1.src_blue;
				res_c.out_alpha = pix_s1.src_alpha;
			end
		endcase

		dw_c.res  = res_c;
		dw_c.over = (mode_s1 == MODE_OVER) && (den_c != '0);
		dw_c.den  = den_c;
		dw_c.rem  = num_c;
		dw_c.quo  = '0;
	end

	logic      v_s2;
	div_word_t dw_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dw_s2 <= dw_c;
		end
	end

	// ---------------- stages 3..10: restoring divider ----------------
	// Entry k resolves quotient bit Q_W-1-k. num < 256*den, so 8 bits suffice.
	logic      v_div_s3  [Q_W];
	div_word_t div_pipe_s3 [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_div
		div_word_t        d_in;
		div_word_t        d_nxt;
		logic             v_in;
		logic [NUM_W-1:0] dsh;

		if (k == 0) begin : g_first
			assign d_in = dw_s2;
			assign v_in = v_s2;
		end else begin : g_rest
			assign d_in = div_pipe_s3[k-1];
			assign v_in = v_div_s3[k-1];
		end

		assign dsh = NUM_W'(d_in.den) << (Q_W - 1 - k);

		always_comb begin
			d_nxt = d_in;
			for (int c = 0; c < N_COLOR; c++) begin
				if (d_in.rem[c] >= dsh) begin
					d_nxt.rem[c]             = d_in.rem[c] - dsh;
					d_nxt.quo[c][Q_W-1-k]    = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_div_s3[k] <= 1'b0;
			end else if (en) begin
				v_div_s3[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_pipe_s3[k] <= d_nxt;
			end
		end
	end

	// ---------------- output ----------------
	div_word_t last;
	assign last        = div_pipe_s3[Q_W-1];
	assign blend_valid = v_div_s3[Q_W-1];

	always_comb begin
		blend = last.res;
		if (last.over) begin
			blend.out_red   = last.quo[0];
			blend.out_green = last.quo[1];
			blend.out_blue  = last.quo[2];
		end
	end

	// ---------------- assertions ----------------
	// Over with a nonzero divisor always leaves an alpha of at least 1.
	a_over_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		blend_valid && last.over |-> blend.out_alpha != '0)
		else $error("over result with zero alpha");

	// Divider must end with every remainder below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		blend_valid && last.over |->
			last.rem[0] < NUM_W'(last.den) && last.rem[1] < NUM_W'(last.den)
			&& last.rem[2] < NUM_W'(last.den))
		else $error("divider remainder not reduced");

	// A stage-one word only appears from an accepted input word.
	a_s1_src: assert property (@(posedge clk) disable iff (!arst_n)
		en && !pix_valid |=> !v_s1)
		else $error("stage one valid without accepted input");

	// A held output word keeps the stage-two valid bit and word frozen.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		blend_valid && blend_stall |=> $stable(v_s2) && $stable(dw_s2))
		else $error("pipeline moved during output stall");

endmodule

// ===== verif/tb_rgba_pixel_blend.sv =====
// tb_rgba_pixel_blend: self-checking bench for the RGBA8 pixel blender, copy/add/over modes.
// Depends on rpb_pkg (word types, mode codes) and rgba_pixel_blend; a ledger class predicts
// each blended word from the accepted pixel word and checks the output stream in order.
module tb_rgba_pixel_blend;
	import rpb_pkg::*;

	// Mode code 3 is unused by the block and must fall back to copy.
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	localparam int STALL_PCT   = 24;    // idle / stall odds per cycle, in percent
	localparam int N_PHASE     = 8;
	localparam int PHASE_WORDS = 175;   // 8 x 175 = 1400 random pixel words
	localparam int QUIET_PHASE = 3;     // phase run with no idling on either side
	localparam int IDLE_LIMIT  = 2000;  // cycles with no handshake before we give up
	localparam int TAIL_CYCLES = 20;    // tail after the last drain, watching for stray words

	localparam logic [MODE_W-1:0] PHASE_MODE [N_PHASE] = '{
		MODE_OVER, MODE_ADD, MODE_COPY, MODE_OVER,
		MODE_SPARE, MODE_ADD, MODE_OVER, MODE_COPY
	};
	localparam logic [MODE_W-1:0] CORNER_MODE [4] = '{
		MODE_COPY, MODE_ADD, MODE_OVER, MODE_SPARE
	};

	// Corner pixels, run under every mode.
	// Field order: dest r,g,b,a then src r,g,b,a.
	localparam pix_word_t CORNER_PIX [6] = '{
		// all zero: zero divisor in over mode
		{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		// all ones: add saturates on every colour
		{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff},
		// both alphas zero but live colours: over must still give all zero
		{8'hff, 8'h00, 8'h80, 8'h00, 8'h01, 8'hfe, 8'h7f, 8'h00},
		// opaque source over clear destination
		{8'h10, 8'h20, 8'h30, 8'h00, 8'hc0, 8'hd0, 8'he0, 8'hff},
		// clear source over opaque destination: add contributes nothing
		{8'hff, 8'hfe, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00},
		// mid alphas, uneven colours
		{8'hc8, 8'h64, 8'hfa, 8'h80, 8'h40, 8'hf0, 8'h99, 8'h7f}
	};

	// Ledger of blended words still owed by the block, with its own copy of the mode.
	class blend_ledger;
		logic [MODE_W-1:0] mode;
		blend_word_t       due[$];
		int unsigned       errors;

		function new();
			mode   = MODE_COPY;
			errors = 0;
		endfunction

		// Exact integer blend of one pixel word under the current mode.
		function blend_word_t blend_pixel(pix_word_t p);
			int unsigned cd[3];
			int unsigned cs[3];
			int unsigned col[3];
			int unsigned sa;
			int unsigned da;
			int unsigned den;
			int unsigned sum;
			blend_word_t r;
			cd  = '{p.dest_red, p.dest_green, p.dest_blue};
			cs  = '{p.src_red, p.src_green, p.src_blue};
			col = '{0, 0, 0};
			sa  = p.src_alpha;
			da  = p.dest_alpha;
			r   = '0;
			case (mode)
			MODE_ADD: begin
				// colour gains cs*as/255, floored, clipped at full scale
				for (int i = 0; i < 3; i++) begin
					sum    = cd[i] + (cs[i] * sa) / 255;
					col[i] = (sum > 255) ? 255 : sum;
				end
				r.out_alpha = p.dest_alpha;
			end
			MODE_OVER: begin
				// straight-alpha over; both alphas zero leaves everything zero
				den = sa * 255 + da * (255 - sa);
				if (den != 0) begin
					for (int i = 0; i < 3; i++)
						col[i] = (cs[i] * sa * 255 + cd[i] * da * (255 - sa)) / den;
					r.out_alpha = CH_W'(den / 255);
				end
			end
			default: begin
				// copy, and the spare code too
				col         = cs;
				r.out_alpha = p.src_alpha;
			end
			endcase
			r.out_red   = CH_W'(col[0]);
			r.out_green = CH_W'(col[1]);
			r.out_blue  = CH_W'(col[2]);
			return r;
		endfunction

		function void take_pixel(pix_word_t p);
			due.push_back(blend_pixel(p));
		endfunction

		function int field_bad(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
			if (want === got)
				return 0;
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		endfunction

		function void match_blend(blend_word_t got);
			blend_word_t want;
			if (due.size() == 0) begin
				$error("blend word %h arrived with no pixel pending", got);
				errors++;
				return;
			end
			want = due.pop_front();
			errors += field_bad("out_red",   want.out_red,   got.out_red);
			errors += field_bad("out_green", want.out_green, got.out_green);
			errors += field_bad("out_blue",  want.out_blue,  got.out_blue);
			errors += field_bad("out_alpha", want.out_alpha, got.out_alpha);
		endfunction
	endclass

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                mode_we     = 1'b0;
	logic [MODE_W-1:0]   mode_wdata  = '0;
	logic                pix_valid   = 1'b0;
	logic                pix_stall;
	pix_word_t           pix         = '0;
	logic                blend_valid;
	logic                blend_stall = 1'b0;
	blend_word_t         blend;

	logic                idle_on     = 1'b1;   // gaps and stalls allowed
	int unsigned         idle_cycles = 0;
	blend_ledger         ledger;

	rgba_pixel_blend uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode_we     (mode_we),
		.mode_wdata  (mode_wdata),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pix         (pix),
		.blend_valid (blend_valid),
		.blend_stall (blend_stall),
		.blend       (blend)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver side: random stall, decided at the falling edge, off in the quiet phase.
	always @(negedge clk) begin
		blend_stall <= idle_on && ($urandom_range(99) < STALL_PCT);
	end

	// Everything is sampled at the rising edge, where both handshakes resolve.
	// The mode copy follows the write at the same edge the block takes it.
	always @(posedge clk) begin
		if (mode_we)
			ledger.mode = mode_wdata;
		if (pix_valid && !pix_stall)
			ledger.take_pixel(pix);
		if (blend_valid && !blend_stall)
			ledger.match_blend(blend);

		// Watchdog: too long with no word moving either way.
		if ((pix_valid && !pix_stall) || (blend_valid && !blend_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_rgba_pixel_blend: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Channel value biased toward the rails so saturation and zero alphas show up often.
	function automatic logic [CH_W-1:0] rand_chan();
		case ($urandom_range(7))
		0: return '0;
		1: return CH_MAX;
		default: return CH_W'($urandom_range(255));
		endcase
	endfunction

	// Offer one pixel word; it holds, unchanged, until the block takes it.
	// Gaps go in before raising valid, never while a word is on offer.
	task automatic send_pixel(input pix_word_t w);
		@(negedge clk);
		while (idle_on && ($urandom_range(99) < STALL_PCT)) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= w;
		do @(posedge clk); while (pix_stall);
	endtask

	// Drop valid and wait for every owed blend word to come out.
	task automatic drain();
		@(negedge clk);
		pix_valid <= 1'b0;
		while (ledger.due.size() != 0)
			@(posedge clk);
	endtask

	// Mode changes only with the pipe empty; every word makes one result,
	// so an empty ledger means an empty pipe.
	task automatic set_mode(input logic [MODE_W-1:0] m);
		drain();
		@(negedge clk);
		mode_we    <= 1'b1;
		mode_wdata <= m;
		@(negedge clk);
		mode_we    <= 1'b0;
	endtask

	initial begin
		ledger = new();

		// Single reset at the start.
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: every corner pixel under every mode code.
		foreach (CORNER_MODE[m]) begin
			set_mode(CORNER_MODE[m]);
			foreach (CORNER_PIX[k])
				send_pixel(CORNER_PIX[k]);
		end

		// Random phases, each with its own mode; one phase runs with no gaps or stalls.
		for (int ph = 0; ph < N_PHASE; ph++) begin
			idle_on = (ph != QUIET_PHASE);
			set_mode(PHASE_MODE[ph]);
			repeat (PHASE_WORDS)
				send_pixel({rand_chan(), rand_chan(), rand_chan(), rand_chan(),
					rand_chan(), rand_chan(), rand_chan(), rand_chan()});
		end

		// Let the last words out, then watch a little longer for strays.
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (ledger.errors == 0)
			$display("tb_rgba_pixel_blend: PASS");
		else
			$display("tb_rgba_pixel_blend: FAIL");
		$finish;
	end

endmodule

// ===== rgba_pixel_blend.f =====
design/rpb_pkg.sv
design/rgba_pixel_blend.sv
verif/tb_rgba_pixel_blend.sv
